### src/rip_pkg.sv
// ----------------------------------------------------------------------------
// rip_pkg: shared types and constants of the radix integer parser
// Payload structs, error codes, range codes and the decimal-digit block table.
// ----------------------------------------------------------------------------
package rip_pkg;

  typedef enum logic [1:0] {
    ErrOk     = 2'd0,
    ErrFormat = 2'd1,
    ErrRange  = 2'd2,
    ErrRadix  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    Width8  = 2'd0,
    Width16 = 2'd1,
    Width32 = 2'd2,
    Width64 = 2'd3
  } width_e;

  typedef struct packed {
    logic [20:0] code_point;
    logic        first_char;
    logic        last_char;
    logic        empty_text;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] parsed_value;
    err_e               error_code;
  } out_item_t;

  typedef struct packed {
    logic [5:0] number_base;
    width_e     result_width;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } digit_t;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] CfgNumberBase  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgResultWidth = 1'd1;

  localparam logic [5:0] BaseReset = 6'd10;
  localparam logic [5:0] BaseMin   = 6'd2;
  localparam logic [5:0] BaseMax   = 6'd36;

  localparam logic [20:0] CharPlus    = 21'h00002B;
  localparam logic [20:0] CharMinus   = 21'h00002D;
  localparam logic [20:0] CharZero    = 21'h000030;
  localparam logic [20:0] CharNine    = 21'h000039;
  localparam logic [20:0] CharUpperA  = 21'h000041;
  localparam logic [20:0] CharUpperZ  = 21'h00005A;
  localparam logic [20:0] CharLowerA  = 21'h000061;
  localparam logic [20:0] CharLowerZ  = 21'h00007A;
  localparam logic [20:0] FullUpperA  = 21'h00FF21;
  localparam logic [20:0] FullUpperZ  = 21'h00FF3A;
  localparam logic [20:0] FullLowerA  = 21'h00FF41;
  localparam logic [20:0] FullLowerZ  = 21'h00FF5A;
  localparam logic [5:0]  LetterBase  = 6'd10;

  localparam int unsigned NumZeroBlocks = 37;
  localparam logic [20:0] ZeroPoints [NumZeroBlocks] = '{
    21'h0030, 21'h0660, 21'h06F0, 21'h07C0, 21'h0966, 21'h09E6, 21'h0A66,
    21'h0AE6, 21'h0B66, 21'h0BE6, 21'h0C66, 21'h0CE6, 21'h0D66, 21'h0DE6,
    21'h0E50, 21'h0ED0, 21'h0F20, 21'h1040, 21'h1090, 21'h17E0, 21'h1810,
    21'h1946, 21'h19D0, 21'h1A80, 21'h1A90, 21'h1B50, 21'h1BB0, 21'h1C40,
    21'h1C50, 21'hA620, 21'hA8D0, 21'hA900, 21'hA9D0, 21'hA9F0, 21'hAA50,
    21'hABF0, 21'hFF10
  };

  // accumulator limits, sign extended to the product width
  localparam logic signed [71:0] LimNeg64 = -72'sh0_8000_0000_0000_0000;
  localparam logic signed [71:0] LimPos64 = -72'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [71:0] LimNeg32 = -72'sh0_0000_0000_8000_0000;
  localparam logic signed [71:0] LimPos32 = -72'sh0_0000_0000_7FFF_FFFF;

  localparam logic signed [63:0] Min8  = -64'sd128;
  localparam logic signed [63:0] Max8  = 64'sd127;
  localparam logic signed [63:0] Min16 = -64'sd32768;
  localparam logic signed [63:0] Max16 = 64'sd32767;

endpackage

### src/radix_integer_parser_unit.sv
// ----------------------------------------------------------------------------
// radix_integer_parser_unit: streaming radix string-to-integer parser
// Input register, digit decode, accumulator and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one code point
//   per transaction, with first/last marks or an empty-numeral flag.
//   Output channel (out_valid_o / out_stall_i / out_item_o) carries one
//   transaction per numeral, at its last character: value and error code.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes the radix
//   (index 0) or the result range (index 1); ready is always high, and
//   writes are expected only while the parser is idle.
//   Throughput: one character per cycle, except while a stalled result holds a
//   last character in the input register. A result is registered: its last
//   character waits in the input register, then passes through the digit
//   decode, multiply-subtract and compare into the result register.
//   Reset: radix 10, 32-bit range, numeral state cleared, no result pending.
//   A stalled result holds; the next last character then waits in the input
//   register, while characters that end no numeral keep flowing.
// ----------------------------------------------------------------------------
module radix_integer_parser_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rip_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rip_pkg::out_item_t               out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rip_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rip_pkg::CfgDataW-1:0]     cfg_data_i
);
  import rip_pkg::*;

  cfg_t      cfg_q;
  logic      s1_vld_q, s1_vld_d;
  in_item_t  s1_item_q;
  logic      out_vld_q;
  out_item_t out_item_q;
  logic      in_fire, out_ready, consume;
  digit_t    digit;
  out_item_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{number_base: BaseReset, result_width: Width32};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNumberBase:  cfg_q.number_base  <= cfg_data_i;
        CfgResultWidth: cfg_q.result_width <= width_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign consume    = s1_vld_q && (!s1_item_q.last_char || out_ready);
  assign in_stall_o = s1_vld_q && !consume;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_vld_d   = in_fire || (s1_vld_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
  end

  rip_digit_decode u_decode (
    .code_point_i (s1_item_q.code_point),
    .digit_o      (digit)
  );

  rip_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (consume),
    .item_i   (s1_item_q),
    .digit_i  (digit),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (consume && s1_item_q.last_char) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && s1_item_q.last_char) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

### src/rip_digit_decode.sv
// ----------------------------------------------------------------------------
// rip_digit_decode: code point to digit value
// ASCII and fullwidth letters and digits of the Unicode decimal-digit blocks.
// ----------------------------------------------------------------------------
module rip_digit_decode (
  input  logic [20:0]     code_point_i,
  output rip_pkg::digit_t digit_o
);
  import rip_pkg::*;

  logic       blk_hit;
  logic [5:0] blk_val;

  always_comb begin
    blk_hit = 1'b0;
    blk_val = '0;
    for (int k = 0; k < NumZeroBlocks; k++) begin
      if (!blk_hit && code_point_i >= ZeroPoints[k] &&
          code_point_i < ZeroPoints[k] + 21'd10) begin
        blk_hit = 1'b1;
        blk_val = 6'(code_point_i - ZeroPoints[k]);
      end
    end
  end

  always_comb begin
    digit_o = '0;
    if (code_point_i >= CharZero && code_point_i <= CharNine) begin
      digit_o = '{valid: 1'b1, value: 6'(code_point_i - CharZero)};
    end else if (code_point_i >= CharLowerA && code_point_i <= CharLowerZ) begin
      digit_o = '{valid: 1'b1, value: 6'(code_point_i - CharLowerA) + LetterBase};
    end else if (code_point_i >= CharUpperA && code_point_i <= CharUpperZ) begin
      digit_o = '{valid: 1'b1, value: 6'(code_point_i - CharUpperA) + LetterBase};
    end else if (code_point_i >= FullUpperA && code_point_i <= FullUpperZ) begin
      digit_o = '{valid: 1'b1, value: 6'(code_point_i - FullUpperA) + LetterBase};
    end else if (code_point_i >= FullLowerA && code_point_i <= FullLowerZ) begin
      digit_o = '{valid: 1'b1, value: 6'(code_point_i - FullLowerA) + LetterBase};
    end else begin
      digit_o = '{valid: blk_hit, value: blk_val};
    end
  end

endmodule

### src/rip_accum.sv
// ----------------------------------------------------------------------------
// rip_accum: numeral state and result logic
// Negative accumulator, sign and sticky error; builds the result at the end.
// ----------------------------------------------------------------------------
module rip_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  rip_pkg::in_item_t  item_i,
  input  rip_pkg::digit_t    digit_i,
  input  rip_pkg::cfg_t      cfg_i,
  output rip_pkg::out_item_t result_o
);
  import rip_pkg::*;

  logic signed [63:0] acc_q, acc_d, acc0, acc_n;
  logic               minus_q, minus_d, minus0, minus_n;
  err_e               err_q, err_d, err0, err_n;
  logic               so_q, so_d, so0, so_n;

  logic               radix_ok, dig_ok;
  logic signed [71:0] prod, diff, limit;
  logic signed [63:0] val;
  err_e               err_out;

  assign acc0   = item_i.first_char ? '0 : acc_q;
  assign minus0 = item_i.first_char ? 1'b0 : minus_q;
  assign err0   = item_i.first_char ? ErrOk : err_q;
  assign so0    = item_i.first_char ? 1'b0 : so_q;

  assign radix_ok = cfg_i.number_base >= BaseMin && cfg_i.number_base <= BaseMax;
  assign dig_ok   = radix_ok && digit_i.valid && digit_i.value < cfg_i.number_base;

  always_comb begin
    if (cfg_i.result_width == Width64) begin
      limit = minus0 ? LimNeg64 : LimPos64;
    end else begin
      limit = minus0 ? LimNeg32 : LimPos32;
    end
  end

  assign prod = 72'(acc0) * $signed({1'b0, cfg_i.number_base});
  assign diff = prod - $signed({66'd0, digit_i.value});

  always_comb begin
    acc_n   = acc0;
    minus_n = minus0;
    err_n   = err0;
    so_n    = so0;
    if (item_i.empty_text) begin
      if (err0 == ErrOk) err_n = ErrFormat;
    end else if (item_i.first_char && item_i.code_point < CharZero) begin
      if (item_i.code_point == CharMinus) begin
        minus_n = 1'b1;
        so_n    = 1'b1;
      end else if (item_i.code_point == CharPlus) begin
        so_n = 1'b1;
      end else begin
        err_n = ErrFormat;
      end
    end else begin
      so_n = 1'b0;
      if (err0 == ErrOk) begin
        if (!dig_ok) begin
          err_n = ErrFormat;
        end else if (diff < limit) begin
          err_n = ErrRange;
        end else begin
          acc_n = diff[63:0];
        end
      end
    end
  end

  always_comb begin
    val     = minus_n ? acc_n : -acc_n;
    err_out = ErrOk;
    if (!radix_ok) begin
      err_out = ErrRadix;
    end else if (err_n != ErrOk) begin
      err_out = err_n;
    end else if (so_n) begin
      err_out = ErrFormat;
    end else if (cfg_i.result_width == Width8 && (val < Min8 || val > Max8)) begin
      err_out = ErrRange;
    end else if (cfg_i.result_width == Width16 && (val < Min16 || val > Max16)) begin
      err_out = ErrRange;
    end
    result_o.error_code   = err_out;
    result_o.parsed_value = (err_out == ErrOk) ? val : '0;
  end

  // a finished numeral leaves no state behind
  assign acc_d   = item_i.last_char ? '0 : acc_n;
  assign minus_d = item_i.last_char ? 1'b0 : minus_n;
  assign err_d   = item_i.last_char ? ErrOk : err_n;
  assign so_d    = item_i.last_char ? 1'b0 : so_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      minus_q <= 1'b0;
      err_q   <= ErrOk;
      so_q    <= 1'b0;
    end else if (step_i) begin
      acc_q   <= acc_d;
      minus_q <= minus_d;
      err_q   <= err_d;
      so_q    <= so_d;
    end
  end

endmodule

### src/rip_checker.sv
// ----------------------------------------------------------------------------
// rip_checker: port-level checks of the radix integer parser
// Result channel behavior and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module rip_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input rip_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rip_pkg::out_item_t out_item_o
);
  import rip_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.error_code != ErrOk |-> out_item_o.parsed_value == '0)
    else $error("nonzero value with an error");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && in_item_i.last_char, 2))
    else $error("result without a last character two cycles earlier");

endmodule

bind radix_integer_parser_unit rip_checker u_rip_checker (.*);

### test/tb_radix_integer_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_integer_parser_unit: self-checking bench of the radix integer parser
// Streams numerals one code point per transaction and compares every result
// with an in-bench parser that tracks the radix and range registers. Directed
// cases cover signs, digit scripts, narrow ranges, radix errors and framing.
// Random phases then sweep radix and range settings with mostly well-formed
// numerals of many sizes, some near the range limits, plus broken numerals
// and noise. Both sides idle in random bursts except in the closing phases.
// ----------------------------------------------------------------------------
module tb_radix_integer_parser_unit;
  import rip_pkg::*;

  localparam int WatchdogLimit = 500;
  localparam int SettleCycles  = 4;

  localparam logic [20:0] ChBang  = 21'h000021;
  localparam logic [20:0] ChPlus  = 21'h00002B;
  localparam logic [20:0] ChMinus = 21'h00002D;
  localparam logic [20:0] ChZero  = 21'h000030;
  localparam logic [20:0] ChUpA   = 21'h000041;
  localparam logic [20:0] ChLowA  = 21'h000061;
  localparam logic [20:0] FwUpA   = 21'h00FF21;
  localparam logic [20:0] FwLowA  = 21'h00FF41;
  localparam int          LetterOffset = 10;

  localparam logic [20:0] DecZero [37] = '{
    21'h0030, 21'h0660, 21'h06F0, 21'h07C0, 21'h0966, 21'h09E6, 21'h0A66,
    21'h0AE6, 21'h0B66, 21'h0BE6, 21'h0C66, 21'h0CE6, 21'h0D66, 21'h0DE6,
    21'h0E50, 21'h0ED0, 21'h0F20, 21'h1040, 21'h1090, 21'h17E0, 21'h1810,
    21'h1946, 21'h19D0, 21'h1A80, 21'h1A90, 21'h1B50, 21'h1BB0, 21'h1C40,
    21'h1C50, 21'hA620, 21'hA8D0, 21'hA900, 21'hA9D0, 21'hA9F0, 21'hAA50,
    21'hABF0, 21'hFF10
  };

  // code points just outside the digit and letter ranges
  localparam logic [20:0] Fringe [12] = '{
    21'h002F, 21'h003A, 21'h0040, 21'h005B, 21'h0060, 21'h007B,
    21'hFF20, 21'hFF3B, 21'hFF40, 21'hFF5B, 21'hFF1A, 21'h065F
  };

  localparam logic [5:0] BaseList [12] = '{
    6'd2, 6'd36, 6'd10, 6'd16, 6'd0, 6'd8, 6'd3, 6'd63, 6'd35, 6'd37, 6'd20, 6'd1
  };
  localparam int Pow2 [8] = '{7, 8, 15, 16, 31, 32, 63, 64};

  localparam longint Lo64 = 64'sh8000_0000_0000_0000;
  localparam longint Hi64 = -64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint Lo32 = -64'sd2147483648;
  localparam longint Hi32 = -64'sd2147483647;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_item_t   in_item_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_item_t  out_item_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  radix_integer_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // parser state mirrored in the bench
  logic [5:0] base_q;
  width_e     width_q;
  longint     acc_q;
  bit         minus_q;
  bit         sign_only_q;
  err_e       sticky_q;

  out_item_t  numeral_results_q [$];
  out_item_t  want;
  int         chars_sent;
  int         numerals_checked;
  int         cfg_writes;
  int         mismatches;
  int         code_tally [4];
  int         idle_cycles;
  bit         in_idle_on;
  bit         out_idle_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- parser
  function automatic void clear_numeral();
    acc_q       = 0;
    minus_q     = 1'b0;
    sign_only_q = 1'b0;
    sticky_q    = ErrOk;
  endfunction

  function automatic void flag_error(err_e code);
    if (sticky_q == ErrOk) sticky_q = code;
  endfunction

  function automatic bit radix_valid(logic [5:0] radix);
    return radix >= 6'd2 && radix <= 6'd36;
  endfunction

  function automatic int digit_value(logic [20:0] cp, logic [5:0] radix);
    int v = -1;
    if (!radix_valid(radix)) return -1;
    if (cp >= ChZero && cp < ChZero + 10) v = int'(cp - ChZero);
    else if (cp >= ChLowA && cp < ChLowA + 26) v = cp - ChLowA + LetterOffset;
    else if (cp >= ChUpA && cp < ChUpA + 26) v = cp - ChUpA + LetterOffset;
    else if (cp >= FwUpA && cp < FwUpA + 26) v = cp - FwUpA + LetterOffset;
    else if (cp >= FwLowA && cp < FwLowA + 26) v = cp - FwLowA + LetterOffset;
    else begin
      foreach (DecZero[k]) begin
        if (v < 0 && cp >= DecZero[k] && cp < DecZero[k] + 10) v = int'(cp - DecZero[k]);
      end
    end
    return (v >= 0 && v < int'(radix)) ? v : -1;
  endfunction

  function automatic void add_digit(logic [20:0] cp);
    longint lim;
    longint mmin;
    longint rdx;
    longint d;
    int     dv;
    if (sticky_q != ErrOk) return;
    dv = digit_value(cp, base_q);
    if (dv < 0) begin
      flag_error(ErrFormat);
      return;
    end
    if (width_q == Width64) lim = minus_q ? Lo64 : Hi64;
    else lim = minus_q ? Lo32 : Hi32;
    rdx  = longint'(base_q);
    d    = longint'(dv);
    mmin = lim / rdx;
    if (acc_q < mmin) begin
      flag_error(ErrRange);
      return;
    end
    acc_q = acc_q * rdx;
    if (acc_q < lim + d) begin
      flag_error(ErrRange);
      return;
    end
    acc_q = acc_q - d;
  endfunction

  function automatic bit parse_char(in_item_t it, output out_item_t res);
    longint val = 0;
    err_e   code;
    if (it.first_char) clear_numeral();
    if (it.empty_text) begin
      flag_error(ErrFormat);
    end else if (it.first_char && it.code_point < ChZero) begin
      if (it.code_point == ChMinus) begin
        minus_q     = 1'b1;
        sign_only_q = 1'b1;
      end else if (it.code_point == ChPlus) begin
        sign_only_q = 1'b1;
      end else begin
        flag_error(ErrFormat);
      end
    end else begin
      sign_only_q = 1'b0;
      add_digit(it.code_point);
    end
    if (!it.last_char) return 1'b0;
    if (!radix_valid(base_q)) code = ErrRadix;
    else if (sticky_q != ErrOk) code = sticky_q;
    else if (sign_only_q) code = ErrFormat;
    else begin
      code = ErrOk;
      val  = minus_q ? acc_q : -acc_q;
      if (width_q == Width8 && (val < -128 || val > 127)) code = ErrRange;
      else if (width_q == Width16 && (val < -32768 || val > 32767)) code = ErrRange;
    end
    if (code != ErrOk) val = 0;
    res.parsed_value = val;
    res.error_code   = code;
    clear_numeral();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_char(in_item_t it);
    out_item_t res;
    if (in_idle_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_char(it, res)) numeral_results_q = {numeral_results_q, res};
    chars_sent++;
  endtask

  task automatic send_numeral(input logic [20:0] cps [$], input bit first_mark,
                              input bit last_mark, input int empty_at);
    in_item_t it;
    foreach (cps[i]) begin
      it            = '0;
      it.code_point = cps[i];
      it.first_char = first_mark && i == 0;
      it.last_char  = last_mark && i == cps.size() - 1;
      it.empty_text = i == empty_at;
      send_char(it);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (numeral_results_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgNumberBase) base_q = data;
    else width_q = width_e'(data[1:0]);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_format(logic [5:0] radix, width_e w);
    write_reg(CfgNumberBase, radix);
    write_reg(CfgResultWidth, CfgDataW'(w));
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_idle_on && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checks
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (numeral_results_q.size() == 0) begin
        $error("result with none pending: parsed_value %0d error_code %0d",
               out_item_o.parsed_value, out_item_o.error_code);
        mismatches++;
      end else begin
        want = numeral_results_q.pop_front();
        if (out_item_o.parsed_value !== want.parsed_value) begin
          $error("parsed_value: expected %0d, actual %0d",
                 want.parsed_value, out_item_o.parsed_value);
          mismatches++;
        end
        if (out_item_o.error_code !== want.error_code) begin
          $error("error_code: expected %0d, actual %0d",
                 want.error_code, out_item_o.error_code);
          mismatches++;
        end
        code_tally[want.error_code]++;
        numerals_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- random text
  function automatic logic [20:0] glyph(int v);
    case ($urandom_range(0, 3))
      0:       return 21'((v < 10) ? ChZero + v : ChLowA + v - LetterOffset);
      1:       return 21'((v < 10) ? DecZero[$urandom_range(0, 36)] + v
                                   : ChUpA + v - LetterOffset);
      2:       return 21'((v < 10) ? ChZero + v : FwUpA + v - LetterOffset);
      default: return 21'((v < 10) ? DecZero[$urandom_range(0, 36)] + v
                                   : FwLowA + v - LetterOffset);
    endcase
  endfunction

  function automatic logic [20:0] bad_glyph();
    case ($urandom_range(0, 4))
      0: return Fringe[$urandom_range(0, 11)];
      1: return 21'(DecZero[$urandom_range(0, 36)] + 10);
      2: return 21'($urandom_range(0, 21'h1FFFFF));
      3: return $urandom_range(0, 1) ? ChMinus : ChPlus;
      default: begin
        if (radix_valid(base_q) && base_q < 6'd36)
          return glyph($urandom_range(base_q, 35));
        return 21'($urandom_range(0, 21'h10FFFF));
      end
    endcase
  endfunction

  function automatic logic [65:0] pick_magnitude();
    case ($urandom_range(0, 5))
      0:       return 66'($urandom_range(0, 40));
      1:       return 66'($urandom_range(0, 70000));
      2:       return (66'd1 << Pow2[$urandom_range(0, 7)]) + $urandom_range(0, 3) - 2;
      3:       return 66'({$urandom, $urandom} >> $urandom_range(0, 63));
      4:       return 66'({$urandom, $urandom});
      default: return {2'($urandom_range(0, 3)), $urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_numeral();
    logic [20:0] cps [$];
    logic [65:0] mag;
    in_item_t    it;
    int          kind;
    int          eff;
    int          empty_at;
    kind     = $urandom_range(0, 19);
    empty_at = -1;
    if (kind == 13) begin
      repeat ($urandom_range(1, 4)) begin
        it.code_point = 21'($urandom_range(0, 21'h1FFFFF));
        it.first_char = 1'($urandom);
        it.last_char  = 1'($urandom);
        it.empty_text = $urandom_range(0, 3) == 0;
        send_char(it);
      end
      return;
    end
    eff = radix_valid(base_q) ? int'(base_q) : 10;
    mag = pick_magnitude();
    do begin
      cps.push_front(glyph(int'(mag % eff)));
      mag = mag / eff;
    end while (mag != 0);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) cps.push_front(glyph(0));
    case ($urandom_range(0, 5))
      0, 1:    cps.push_front(ChMinus);
      2:       cps.push_front(ChPlus);
      default: ;
    endcase
    case (kind)
      14: cps[$urandom_range(0, cps.size() - 1)] = bad_glyph();
      15: cps = '{$urandom_range(0, 1) ? ChMinus : ChPlus};
      16: cps[0] = 21'($urandom_range(0, ChZero - 1));
      17: begin
        if ($urandom_range(0, 1)) cps = '{21'($urandom_range(0, 21'h1FFFFF))};
        empty_at = $urandom_range(0, cps.size() - 1);
      end
      default: ;
    endcase
    send_numeral(cps, kind != 19, kind != 18, empty_at);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_signs_and_format();
    send_numeral('{ChMinus, ChZero + 21'd5}, 1'b1, 1'b1, -1);
    send_numeral('{ChPlus}, 1'b1, 1'b1, -1);
    send_numeral('{ChZero}, 1'b1, 1'b1, 0);
    send_numeral('{ChBang}, 1'b1, 1'b1, -1);
  endtask

  task automatic test_digit_sets();
    set_format(6'd36, Width64);
    send_numeral('{FwLowA + 21'd25}, 1'b1, 1'b1, -1);
    send_numeral('{ChUpA + 21'd25}, 1'b1, 1'b1, -1);
    send_numeral('{DecZero[4] + 21'd9, FwUpA}, 1'b1, 1'b1, -1);
  endtask

  task automatic test_narrow_ranges();
    set_format(6'd16, Width8);
    send_numeral('{ChMinus, ChZero + 21'd8, ChZero}, 1'b1, 1'b1, -1);
    send_numeral('{ChZero + 21'd8, ChZero}, 1'b1, 1'b1, -1);
  endtask

  task automatic test_radix_limits();
    set_format(6'd2, Width32);
    send_numeral('{ChZero + 21'd2}, 1'b1, 1'b1, -1);
    write_reg(CfgNumberBase, 6'd0);
    send_numeral('{ChZero + 21'd1}, 1'b1, 1'b1, -1);
    write_reg(CfgNumberBase, 6'd63);
    send_numeral('{ChZero}, 1'b1, 1'b1, -1);
  endtask

  task automatic test_mid_numeral_config();
    write_reg(CfgNumberBase, 6'd10);
    send_numeral('{ChZero + 21'd1}, 1'b1, 1'b0, -1);
    write_reg(CfgNumberBase, 6'd16);
    send_numeral('{ChLowA + 21'd5}, 1'b0, 1'b1, -1);
  endtask

  task automatic test_framing();
    send_numeral('{ChZero + 21'd1}, 1'b1, 1'b0, -1);
    send_numeral('{ChZero + 21'd2}, 1'b1, 1'b1, -1);
    send_numeral('{ChZero + 21'd5}, 1'b0, 1'b1, -1);
  endtask

  task automatic test_random_sweep();
    logic [5:0] radix;
    int         start;
    int         budget;
    for (int p = 0; p < 15; p++) begin
      in_idle_on  = p < 12;
      out_idle_on = p < 12;
      radix       = (p < 12) ? BaseList[p] : 6'($urandom_range(2, 36));
      write_reg(CfgNumberBase, radix);
      write_reg(CfgResultWidth, {4'($urandom), 2'(p % 4)});
      budget = radix_valid(radix) ? 85 : 25;
      start  = chars_sent;
      while (chars_sent - start < budget) send_random_numeral();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    base_q      = 6'd10;
    width_q     = Width32;
    clear_numeral();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_signs_and_format();
    test_digit_sets();
    test_narrow_ranges();
    test_radix_limits();
    test_mid_numeral_config();
    test_framing();
    test_random_sweep();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (numeral_results_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("%0d characters, %0d numerals checked over %0d register writes",
             chars_sent, numerals_checked, cfg_writes);
    $display("result codes: ok %0d, format %0d, range %0d, radix %0d",
             code_tally[ErrOk], code_tally[ErrFormat], code_tally[ErrRange],
             code_tally[ErrRadix]);
    if (mismatches == 0 && numeral_results_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
